// File: rtl/tle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tle_pkg
// Types and constants shared by the line editor controller and datapath.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_DEPTH = 256;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int LIMIT_W    = 9;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

  localparam logic [LIMIT_W-1:0] LIMIT_MIN = 9'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 9'(LINE_DEPTH);

  localparam logic [LIMIT_W-1:0] RST_LINE_LIMIT      = 9'd256;
  localparam logic [BYTE_W-1:0]  RST_BACKSPACE_CODE  = 8'd8;
  localparam logic [BYTE_W-1:0]  RST_WORD_ERASE_MASK = 8'd5;
  localparam logic [BYTE_W-1:0]  RST_LINE_ERASE_MASK = 8'd8;

  typedef enum logic [1:0] {
    FUNC_CHAR   = 2'd0,
    FUNC_ACTION = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LIMIT      = 2'd0,
    CFG_BACKSPACE_CODE  = 2'd1,
    CFG_WORD_ERASE_MASK = 2'd2,
    CFG_LINE_ERASE_MASK = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TYPE,
    OP_TERM,
    OP_WORD_STEP,
    OP_LINE_ERASE,
    OP_CHAR_ERASE,
    OP_READ_ISSUE,
    OP_READ_CAP
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_ctl_t;

  typedef struct packed {
    func_t func;
    logic  is_bs;
    logic  word_sel;
    logic  line_sel;
    logic  line_end;
    logic  cursor_zero;
    logic  rd_space;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/tle_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tle_dp
// Line store, cursor, configuration registers and result staging.
// ----------------------------------------------------------------------------
module tle_dp import tle_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LIMIT_W-1:0]   cfg_wdata,
  input  wire logic [1:0]           in_func,
  input  wire logic [BYTE_W-1:0]    in_character,
  input  wire logic [BYTE_W-1:0]    in_key_code,
  input  wire logic [BYTE_W-1:0]    in_modifiers,
  input  wire logic [ADDR_W-1:0]    in_read_index,
  input  wire dp_ctl_t              ctl,
  output dp_stat_t                  stat,
  output logic                      out_echo_valid,
  output logic [BYTE_W-1:0]         out_echo_char,
  output logic [BYTE_W-1:0]         out_erase_count,
  output logic                      out_line_done,
  output logic                      out_line_status,
  output logic [BYTE_W-1:0]         out_line_length,
  output logic [BYTE_W-1:0]         out_read_data
);

  logic [BYTE_W-1:0] mem [LINE_DEPTH];

  logic [LIMIT_W-1:0] line_limit_r;
  logic [BYTE_W-1:0]  backspace_code_r;
  logic [BYTE_W-1:0]  word_erase_mask_r;
  logic [BYTE_W-1:0]  line_erase_mask_r;

  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [ADDR_W-1:0] term_addr_r, term_addr_nxt;
  logic [BYTE_W-1:0] rd_data_r;

  logic [1:0]        func_r;
  logic [BYTE_W-1:0] char_r, key_r, mods_r;
  logic [ADDR_W-1:0] ridx_r;

  logic              echo_valid_r, echo_valid_nxt;
  logic [BYTE_W-1:0] echo_char_r, echo_char_nxt;
  logic [BYTE_W-1:0] erase_r, erase_nxt;
  logic              done_r, done_nxt;
  logic              status_r, status_nxt;
  logic [BYTE_W-1:0] length_r, length_nxt;
  logic [BYTE_W-1:0] read_r, read_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;

  logic [LIMIT_W-1:0] eff_limit;
  logic [LIMIT_W:0]   cursor_inc;
  logic               is_newline, is_full;

  always_comb begin
    eff_limit = line_limit_r;
    if (line_limit_r < LIMIT_MIN) eff_limit = LIMIT_MIN;
    if (line_limit_r > LIMIT_MAX) eff_limit = LIMIT_MAX;
  end

  assign cursor_inc = {{(LIMIT_W+1-ADDR_W){1'b0}}, cursor_r} + 1'b1;
  assign is_newline = (char_r == CH_NEWLINE);
  assign is_full    = (cursor_inc >= ({1'b0, eff_limit} - 1'b1));

  assign stat.func        = func_t'(func_r);
  assign stat.is_bs       = (key_r == backspace_code_r);
  assign stat.word_sel    = ((mods_r & word_erase_mask_r) != '0);
  assign stat.line_sel    = ((mods_r & line_erase_mask_r) != '0);
  assign stat.line_end    = is_newline || is_full;
  assign stat.cursor_zero = (cursor_r == '0);
  assign stat.rd_space    = (rd_data_r == CH_SPACE);

  always_comb begin
    cursor_nxt     = cursor_r;
    term_addr_nxt  = term_addr_r;
    echo_valid_nxt = echo_valid_r;
    echo_char_nxt  = echo_char_r;
    erase_nxt      = erase_r;
    done_nxt       = done_r;
    status_nxt     = status_r;
    length_nxt     = length_r;
    read_nxt       = read_r;
    wr_en          = 1'b0;
    wr_addr        = cursor_r;
    wr_data        = char_r;
    rd_addr        = ridx_r;
    if (ctl.load) begin
      echo_valid_nxt = 1'b0;
      echo_char_nxt  = '0;
      erase_nxt      = '0;
      done_nxt       = 1'b0;
      status_nxt     = 1'b0;
      length_nxt     = '0;
      read_nxt       = '0;
    end
    case (ctl.op)
      OP_TYPE: begin
        wr_en          = 1'b1;
        echo_valid_nxt = 1'b1;
        echo_char_nxt  = char_r;
        if (is_newline) begin
          done_nxt      = 1'b1;
          status_nxt    = 1'b0;
          length_nxt    = cursor_r;
          term_addr_nxt = cursor_r;
          cursor_nxt    = '0;
        end else if (is_full) begin
          done_nxt      = 1'b1;
          status_nxt    = 1'b1;
          length_nxt    = cursor_inc[BYTE_W-1:0];
          term_addr_nxt = cursor_inc[ADDR_W-1:0];
          cursor_nxt    = '0;
        end else begin
          cursor_nxt = cursor_inc[ADDR_W-1:0];
        end
      end
      OP_TERM: begin
        wr_en   = 1'b1;
        wr_addr = term_addr_r;
        wr_data = CH_NUL;
      end
      OP_WORD_STEP: begin
        cursor_nxt = cursor_r - 1'b1;
        erase_nxt  = erase_r + 1'b1;
        rd_addr    = cursor_r - 1'b1;
      end
      OP_LINE_ERASE: begin
        erase_nxt  = cursor_r;
        cursor_nxt = '0;
      end
      OP_CHAR_ERASE: begin
        erase_nxt  = 8'd1;
        cursor_nxt = cursor_r - 1'b1;
      end
      OP_READ_ISSUE: rd_addr = ridx_r;
      OP_READ_CAP:   read_nxt = rd_data_r;
      OP_NONE:       ;
      default:       ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r      <= RST_LINE_LIMIT;
      backspace_code_r  <= RST_BACKSPACE_CODE;
      word_erase_mask_r <= RST_WORD_ERASE_MASK;
      line_erase_mask_r <= RST_LINE_ERASE_MASK;
      cursor_r          <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LINE_LIMIT:      line_limit_r      <= cfg_wdata;
          CFG_BACKSPACE_CODE:  backspace_code_r  <= cfg_wdata[BYTE_W-1:0];
          CFG_WORD_ERASE_MASK: word_erase_mask_r <= cfg_wdata[BYTE_W-1:0];
          CFG_LINE_ERASE_MASK: line_erase_mask_r <= cfg_wdata[BYTE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func_r <= in_func;
      char_r <= in_character;
      key_r  <= in_key_code;
      mods_r <= in_modifiers;
      ridx_r <= in_read_index;
    end
    term_addr_r  <= term_addr_nxt;
    echo_valid_r <= echo_valid_nxt;
    echo_char_r  <= echo_char_nxt;
    erase_r      <= erase_nxt;
    done_r       <= done_nxt;
    status_r     <= status_nxt;
    length_r     <= length_nxt;
    read_r       <= read_nxt;
  end

  assign out_echo_valid  = echo_valid_r;
  assign out_echo_char   = echo_char_r;
  assign out_erase_count = erase_r;
  assign out_line_done   = done_r;
  assign out_line_status = status_r;
  assign out_line_length = length_r;
  assign out_read_data   = read_r;

endmodule
`default_nettype wire

// File: rtl/tle_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tle_ctrl
// Sequencer for the line editor: decodes an item and steps the datapath.
// ----------------------------------------------------------------------------
module tle_ctrl import tle_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_ctl_t       ctl,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TERM,
    ST_WORD,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    ctl.load  = start && (state_r == ST_IDLE);
    ctl.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.func)
          FUNC_CHAR: begin
            ctl.op = OP_TYPE;
            if (stat.line_end) begin
              state_nxt = ST_TERM;
            end else begin
              state_nxt = ST_IDLE;
              valid_nxt = 1'b1;
            end
          end
          FUNC_ACTION: begin
            if (stat.is_bs && stat.word_sel && !stat.cursor_zero) begin
              ctl.op    = OP_WORD_STEP;
              state_nxt = ST_WORD;
            end else begin
              if (stat.is_bs && !stat.word_sel && stat.line_sel) begin
                ctl.op = OP_LINE_ERASE;
              end else if (stat.is_bs && !stat.word_sel && !stat.cursor_zero) begin
                ctl.op = OP_CHAR_ERASE;
              end
              state_nxt = ST_IDLE;
              valid_nxt = 1'b1;
            end
          end
          FUNC_READ: begin
            ctl.op    = OP_READ_ISSUE;
            state_nxt = ST_READ;
          end
          default: begin
            state_nxt = ST_IDLE;
            valid_nxt = 1'b1;
          end
        endcase
      end
      ST_TERM: begin
        ctl.op    = OP_TERM;
        state_nxt = ST_IDLE;
        valid_nxt = 1'b1;
      end
      ST_WORD: begin
        if (stat.rd_space || stat.cursor_zero) begin
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
        end else begin
          ctl.op = OP_WORD_STEP;
        end
      end
      ST_READ: begin
        ctl.op    = OP_READ_CAP;
        state_nxt = ST_IDLE;
        valid_nxt = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;

endmodule
`default_nettype wire

// File: rtl/terminal_line_editor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_line_editor
// Canonical-mode line editor driven by key events.
//
// An item (func, character, key_code, modifiers, read_index) is taken at a
// rising edge with start high and busy low. Exactly one result follows,
// shown for one cycle with out_valid high; the receiver cannot stall it.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user is
// to write it only while idle, since the block itself does not enforce this.
// Steps from the accepting edge to the result, by kind of item:
//   plain typed character, single or line erase, ignored keys: decode
//   typed character that ends the line: decode, then terminator write
//   read of a stored byte: decode issuing a registered store read, then capture
//   word erase: decode, then one store read per byte erased
// The line store is a 256 x 8 array with one write and one read port; word
// erase walks it backward one byte per cycle, at most 254 bytes.
// A new item may be accepted in the cycle its predecessor's result shows.
// Reset loads the default configuration and clears the cursor; store
// contents stay undefined until written.
// ----------------------------------------------------------------------------
module terminal_line_editor import tle_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_func,
  input  wire logic [BYTE_W-1:0]    in_character,
  input  wire logic [BYTE_W-1:0]    in_key_code,
  input  wire logic [BYTE_W-1:0]    in_modifiers,
  input  wire logic [ADDR_W-1:0]    in_read_index,
  output logic                      out_valid,
  output logic                      out_echo_valid,
  output logic [BYTE_W-1:0]         out_echo_char,
  output logic [BYTE_W-1:0]         out_erase_count,
  output logic                      out_line_done,
  output logic                      out_line_status,
  output logic [BYTE_W-1:0]         out_line_length,
  output logic [BYTE_W-1:0]         out_read_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LIMIT_W-1:0]   cfg_wdata
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  tle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tle_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_func),
    .in_character    (in_character),
    .in_key_code     (in_key_code),
    .in_modifiers    (in_modifiers),
    .in_read_index   (in_read_index),
    .ctl             (ctl),
    .stat            (stat),
    .out_echo_valid  (out_echo_valid),
    .out_echo_char   (out_echo_char),
    .out_erase_count (out_erase_count),
    .out_line_done   (out_line_done),
    .out_line_status (out_line_status),
    .out_line_length (out_line_length),
    .out_read_data   (out_read_data)
  );

endmodule
`default_nettype wire

// File: tb/terminal_line_editor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// terminal_line_editor_tb
// Drives key events into the line editor and checks every result against a
// cycle-free model of the editor kept in the bench. Directed tests cover
// typing, each erase kind, the line limit corners and the key configuration.
// Random sessions then change the configuration between idle phases.
// ----------------------------------------------------------------------------
module terminal_line_editor_tb;
  import tle_pkg::*;

  localparam logic ST_COMPLETE = 1'b0;
  localparam logic ST_FULL     = 1'b1;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic              echo_valid;
    logic [BYTE_W-1:0] echo_char;
    logic [BYTE_W-1:0] erase_count;
    logic              line_done;
    logic              line_status;
    logic [BYTE_W-1:0] line_length;
    logic [BYTE_W-1:0] read_data;
  } line_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_func;
  logic [BYTE_W-1:0]    in_character;
  logic [BYTE_W-1:0]    in_key_code;
  logic [BYTE_W-1:0]    in_modifiers;
  logic [ADDR_W-1:0]    in_read_index;
  logic                 out_valid;
  logic                 out_echo_valid;
  logic [BYTE_W-1:0]    out_echo_char;
  logic [BYTE_W-1:0]    out_erase_count;
  logic                 out_line_done;
  logic                 out_line_status;
  logic [BYTE_W-1:0]    out_line_length;
  logic [BYTE_W-1:0]    out_read_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_wdata;

  // editor model state
  logic [BYTE_W-1:0]  line_mem [LINE_DEPTH];
  bit                 mem_written [LINE_DEPTH];
  int unsigned        hi_written;
  int unsigned        edit_pos;
  logic [LIMIT_W-1:0] limit_reg;
  logic [BYTE_W-1:0]  bs_code;
  logic [BYTE_W-1:0]  word_mask;
  logic [BYTE_W-1:0]  line_mask;

  line_result_t expected_results [$];
  int           mismatch_count;
  int           stall_cycles;
  int           burst_left;

  terminal_line_editor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_character    (in_character),
    .in_key_code     (in_key_code),
    .in_modifiers    (in_modifiers),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_echo_valid  (out_echo_valid),
    .out_echo_char   (out_echo_char),
    .out_erase_count (out_erase_count),
    .out_line_done   (out_line_done),
    .out_line_status (out_line_status),
    .out_line_length (out_line_length),
    .out_read_data   (out_read_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void store_byte(int unsigned pos, logic [BYTE_W-1:0] val);
    line_mem[pos]    = val;
    mem_written[pos] = 1'b1;
    if (pos > hi_written) begin
      hi_written = pos;
    end
  endfunction

  function automatic void close_line(inout line_result_t r, input int unsigned len,
                                     input logic status);
    store_byte(len, CH_NUL);
    r.line_done   = 1'b1;
    r.line_status = status;
    r.line_length = len[BYTE_W-1:0];
    edit_pos      = 0;
  endfunction

  function automatic line_result_t predict_key_event(logic [1:0] f, logic [BYTE_W-1:0] ch,
                                                     logic [BYTE_W-1:0] key,
                                                     logic [BYTE_W-1:0] mods,
                                                     logic [ADDR_W-1:0] idx);
    line_result_t r;
    int unsigned  lim;
    int unsigned  pos;
    int unsigned  cnt;
    logic         hit;
    r   = '0;
    lim = limit_reg;
    if (lim < LIMIT_MIN) lim = LIMIT_MIN;
    if (lim > LIMIT_MAX) lim = LIMIT_MAX;
    case (func_t'(f))
      FUNC_CHAR: begin
        pos = edit_pos;
        store_byte(pos, ch);
        r.echo_valid = 1'b1;
        r.echo_char  = ch;
        edit_pos     = pos + 1;
        if (ch == CH_NEWLINE) begin
          close_line(r, pos, ST_COMPLETE);
        end else if (edit_pos >= lim - 1) begin
          close_line(r, edit_pos, ST_FULL);
        end
      end
      FUNC_ACTION: begin
        if (key == bs_code) begin
          cnt = 0;
          if ((mods & word_mask) != 0) begin
            hit = 1'b0;
            while (edit_pos > 0 && !hit) begin
              cnt++;
              edit_pos--;
              hit = (line_mem[edit_pos] == CH_SPACE);
            end
          end else if ((mods & line_mask) != 0) begin
            cnt      = edit_pos;
            edit_pos = 0;
          end else if (edit_pos > 0) begin
            cnt = 1;
            edit_pos--;
          end
          r.erase_count = cnt[BYTE_W-1:0];
        end
      end
      FUNC_READ: r.read_data = line_mem[idx];
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 50) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  // result checker, item tracker and watchdog
  always @(posedge clk) begin : monitor
    line_result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 50) begin
            $display("%0t: result with no item pending, expected none, got read_data %0d",
                     $time, out_read_data);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("echo_valid", want.echo_valid, out_echo_valid);
          check_field("echo_char", want.echo_char, out_echo_char);
          check_field("erase_count", want.erase_count, out_erase_count);
          check_field("line_done", want.line_done, out_line_done);
          check_field("line_status", want.line_status, out_line_status);
          check_field("line_length", want.line_length, out_line_length);
          check_field("read_data", want.read_data, out_read_data);
        end
      end
      if (cfg_we === 1'b1) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LINE_LIMIT:      limit_reg = cfg_wdata;
          CFG_BACKSPACE_CODE:  bs_code   = cfg_wdata[BYTE_W-1:0];
          CFG_WORD_ERASE_MASK: word_mask = cfg_wdata[BYTE_W-1:0];
          CFG_LINE_ERASE_MASK: line_mask = cfg_wdata[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_results.push_back(predict_key_event(in_func, in_character, in_key_code,
                                                     in_modifiers, in_read_index));
      end
      if (out_valid === 1'b1 || (start === 1'b1 && busy === 1'b0) || cfg_we === 1'b1) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results pending", $time,
                 expected_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // one item; the sender works in bursts and idles between them
  task automatic send_item(func_t f, logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] key,
                           logic [BYTE_W-1:0] mods, logic [ADDR_W-1:0] idx);
    @(negedge clk);
    start         = 1'b1;
    in_func       = f;
    in_character  = ch;
    in_key_code   = key;
    in_modifiers  = mods;
    in_read_index = idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic type_char(logic [BYTE_W-1:0] ch);
    send_item(FUNC_CHAR, ch, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic press_key(logic [BYTE_W-1:0] key, logic [BYTE_W-1:0] mods);
    send_item(FUNC_ACTION, 8'($urandom), key, mods, 8'($urandom));
  endtask

  task automatic read_byte(logic [ADDR_W-1:0] idx);
    send_item(FUNC_READ, 8'($urandom), 8'($urandom), 8'($urandom), idx);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [LIMIT_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_read_index();
    logic [ADDR_W-1:0] idx;
    do begin
      idx = ADDR_W'($urandom_range(0, hi_written));
    end while (!mem_written[idx]);
    return idx;
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_mask();
    case ($urandom_range(0, 4))
      0:       return 9'h000;
      1:       return 9'h0ff;
      2:       return 9'(1 << $urandom_range(0, 7));
      default: return 9'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_erase_kinds();
    type_char(8'hff);
    type_char(8'h00);
    type_char(CH_SPACE);
    type_char("x");
    read_byte(8'd0);
    press_key(RST_BACKSPACE_CODE, 8'h00);
    type_char("y");
    // word and line modifiers together: word erase wins
    press_key(RST_BACKSPACE_CODE, 8'h0c);
    press_key(RST_BACKSPACE_CODE, 8'h08);
    press_key(RST_BACKSPACE_CODE, 8'h00);
    press_key(8'hff, 8'h00);
    send_item(FUNC_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
    type_char("a");
    type_char(CH_NEWLINE);
    read_byte(8'd1);
  endtask

  task automatic test_limit_cases();
    wait_all_results();
    write_reg(CFG_LINE_LIMIT, 9'd0);
    type_char("q");
    type_char(CH_NEWLINE);
    wait_all_results();
    write_reg(CFG_LINE_LIMIT, 9'd511);
    repeat (4) type_char("m");
    wait_all_results();
    write_reg(CFG_LINE_LIMIT, 9'd3);
    type_char("n");
    wait_all_results();
    write_reg(CFG_LINE_LIMIT, 9'd4);
    type_char("a");
    type_char("b");
    type_char(CH_NEWLINE);
  endtask

  task automatic test_key_config();
    wait_all_results();
    write_reg(CFG_BACKSPACE_CODE, 9'd0);
    write_reg(CFG_WORD_ERASE_MASK, 9'h000);
    write_reg(CFG_LINE_ERASE_MASK, 9'h0ff);
    type_char("a");
    type_char(CH_SPACE);
    type_char("b");
    press_key(8'h00, 8'h01);
    wait_all_results();
    write_reg(CFG_BACKSPACE_CODE, 9'd255);
    write_reg(CFG_WORD_ERASE_MASK, 9'h0ff);
    write_reg(CFG_LINE_ERASE_MASK, 9'h000);
    type_char("c");
    type_char(CH_SPACE);
    type_char("d");
    press_key(8'hff, 8'h80);
    press_key(8'hff, 8'h00);
    press_key(RST_BACKSPACE_CODE, 8'h00);
  endtask

  task automatic test_random_sessions();
    int                unsigned n;
    int                unsigned roll;
    int                unsigned sel;
    bit                long_lines;
    func_t             f;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] key;
    logic [BYTE_W-1:0] mods;
    logic [ADDR_W-1:0] idx;
    for (int p = 0; p < 7; p++) begin
      wait_all_results();
      long_lines = (p == 1 || p == 4);
      if (long_lines) begin
        write_reg(CFG_LINE_LIMIT, (p == 1) ? 9'd256 : 9'd511);
      end else if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_LINE_LIMIT, 9'($urandom_range(0, 1)));
          1:       write_reg(CFG_LINE_LIMIT, 9'($urandom_range(2, 6)));
          2:       write_reg(CFG_LINE_LIMIT, 9'($urandom_range(7, 64)));
          3:       write_reg(CFG_LINE_LIMIT, 9'd256);
          4:       write_reg(CFG_LINE_LIMIT, 9'($urandom_range(257, 511)));
          default: write_reg(CFG_LINE_LIMIT, 9'($urandom_range(2, 256)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CFG_BACKSPACE_CODE, ($urandom_range(0, 3) == 0) ?
                  9'($urandom_range(0, 1) * 255) : 9'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) != 0) write_reg(CFG_WORD_ERASE_MASK, pick_mask());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_LINE_ERASE_MASK, pick_mask());
      n = long_lines ? 340 : 185;
      repeat (n) begin
        roll = $urandom_range(0, 99);
        f    = FUNC_CHAR;
        ch   = 8'($urandom);
        key  = 8'($urandom);
        mods = 8'($urandom);
        idx  = 8'($urandom);
        if (long_lines) begin
          if (roll < 95) begin
            ch = ($urandom_range(0, 6) == 0) ? CH_SPACE : 8'($urandom_range(97, 122));
          end else if (roll < 98) begin
            f   = FUNC_READ;
            idx = pick_read_index();
          end else begin
            f    = FUNC_ACTION;
            key  = bs_code;
            mods = mods & ~(word_mask | line_mask);
          end
        end else if (roll < 50) begin
          sel = $urandom_range(0, 99);
          if (sel < 15) ch = CH_SPACE;
          else if (sel < 18) ch = CH_NEWLINE;
          else if (sel >= 25) ch = 8'($urandom_range(97, 122));
        end else if (roll < 62) begin
          f    = FUNC_ACTION;
          key  = bs_code;
          mods = mods & ~(word_mask | line_mask);
        end else if (roll < 70) begin
          f   = FUNC_ACTION;
          key = bs_code;
          if ((mods & word_mask) == 0) mods = mods | word_mask;
        end else if (roll < 76) begin
          f    = FUNC_ACTION;
          key  = bs_code;
          mods = (mods & ~word_mask) | line_mask;
        end else if (roll < 86) begin
          f   = FUNC_READ;
          idx = pick_read_index();
        end else if (roll < 94) begin
          f = FUNC_ACTION;
        end else begin
          f = FUNC_UNUSED;
        end
        send_item(f, ch, key, mods, idx);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = FUNC_CHAR;
    in_character  = '0;
    in_key_code   = '0;
    in_modifiers  = '0;
    in_read_index = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_LINE_LIMIT;
    cfg_wdata     = '0;
    foreach (mem_written[i]) mem_written[i] = 1'b0;
    hi_written     = 0;
    edit_pos       = 0;
    limit_reg      = RST_LINE_LIMIT;
    bs_code        = RST_BACKSPACE_CODE;
    word_mask      = RST_WORD_ERASE_MASK;
    line_mask      = RST_LINE_ERASE_MASK;
    mismatch_count = 0;
    stall_cycles   = 0;
    burst_left     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_erase_kinds();
    test_limit_cases();
    test_key_config();
    test_random_sessions();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
